// File: hdl/bmhq_pkg.sv
// bmhq_pkg: shared types and constants for the binary min-heap queue
// operation and status codes, sequencer states, default sizes
// no dependencies
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int HEAP_DEPTH_DEF    = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int KEY_WIDTH         = 32;
  localparam int PORT_WIDTH        = 32;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_R,
    ST_DN_MOVE,
    ST_OUT
  } state_t;

endpackage

// File: hdl/bmhq_ram.sv
// bmhq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/binary_min_heap_queue.sv
// binary_min_heap_queue: min-heap priority queue top level
// uses bmhq_pkg and one bmhq_ram instance for the heap store
//
// usage:
//   request channel (in_valid/in_ready) carries func, payload_in, key_in;
//   func push inserts payload and signed 16.16 key, func pop removes the
//   entry with the smallest key. result channel (out_valid/out_ready)
//   returns payload_out, status (ok, empty, full), entries_left, is_empty.
//   one request is worked at a time; in_ready is high only while idle.
//   a push walks up from its new slot, reading each parent in turn and
//   moving it down while the new key is smaller; a full push or an empty
//   pop goes straight to the result.
//   a pop reads the root, then the last entry, which it carries down from
//   the root past each smaller child (one shared key comparator and one
//   store read port, so each child and parent read is its own state); a pop
//   that takes the last entry skips the walk down. the sequencer returns to
//   idle after each delivered result before the next request is taken.
//   a result waits in its output register while out_ready is low; no new
//   request is taken until it is delivered.
//   reset clears the entry count and the sequencer; the store itself is not
//   cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps

module binary_min_heap_queue #(
  parameter int HEAP_DEPTH    = bmhq_pkg::HEAP_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = bmhq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic [bmhq_pkg::PORT_WIDTH-1:0]      payload_in,
  input  logic signed [bmhq_pkg::KEY_WIDTH-1:0] key_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bmhq_pkg::PORT_WIDTH-1:0]      payload_out,
  output logic [1:0]                           status,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]      entries_left,
  output logic                                 is_empty
);

  import bmhq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int EW = PAYLOAD_WIDTH + KEY_WIDTH;
  localparam int XW = AW + 2;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] best_pos, best_pos_next;
  logic          best_child, best_child_next;
  logic signed [KEY_WIDTH-1:0] cur_key, cur_key_next;
  logic signed [KEY_WIDTH-1:0] best_key, best_key_next;
  logic [PAYLOAD_WIDTH-1:0] cur_pay, cur_pay_next;
  logic [PAYLOAD_WIDTH-1:0] best_pay, best_pay_next;
  logic [PAYLOAD_WIDTH-1:0] res_payload, res_payload_next;
  status_t res_status, res_status_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic signed [KEY_WIDTH-1:0] rd_key;
  logic [PAYLOAD_WIDTH-1:0]    rd_pay;

  logic signed [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic          cmp_lt;
  logic [AW-1:0] pos_m1, parent;
  logic [XW-1:0] l_ext, r_ext, count_ext;
  logic          l_ok, r_ok;

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[KEY_WIDTH-1:0];
  assign rd_pay = ram_rdata[EW-1:KEY_WIDTH];

  // heap index arithmetic
  assign pos_m1    = pos - 1'b1;
  assign parent    = pos_m1 >> 1;
  assign l_ext     = {1'b0, pos, 1'b1};
  assign r_ext     = l_ext + 1'b1;
  assign count_ext = XW'(count);
  assign l_ok      = l_ext < count_ext;
  assign r_ok      = r_ext < count_ext;

  // the one shared key comparator
  always_comb begin
    case (state)
      ST_UP_CMP: begin
        cmp_a = cur_key;
        cmp_b = rd_key;
      end
      ST_DN_R: begin
        cmp_a = rd_key;
        cmp_b = best_key;
      end
      default: begin
        cmp_a = rd_key;
        cmp_b = cur_key;
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    best_pos    <= best_pos_next;
    best_child  <= best_child_next;
    cur_key     <= cur_key_next;
    cur_pay     <= cur_pay_next;
    best_key    <= best_key_next;
    best_pay    <= best_pay_next;
    res_payload <= res_payload_next;
    res_status  <= res_status_next;
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    pos_next         = pos;
    best_pos_next    = best_pos;
    best_child_next  = best_child;
    cur_key_next     = cur_key;
    cur_pay_next     = cur_pay;
    best_key_next    = best_key;
    best_pay_next    = best_pay;
    res_payload_next = res_payload;
    res_status_next  = res_status;
    ram_we           = 1'b0;
    ram_waddr        = pos;
    ram_wdata        = {cur_pay, cur_key};
    ram_raddr        = '0;
    in_ready         = 1'b0;
    out_valid        = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_pay_next     = payload_in[PAYLOAD_WIDTH-1:0];
          cur_key_next     = key_in;
          res_payload_next = '0;
          res_status_next  = STAT_OK;
          if (func == FUNC_PUSH) begin
            if (count == CW'(HEAP_DEPTH)) begin
              res_status_next = STAT_FULL;
              state_next      = ST_OUT;
            end else begin
              pos_next   = count[AW-1:0];
              count_next = count + 1'b1;
              state_next = ST_UP_CHK;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
              state_next      = ST_OUT;
            end else begin
              ram_raddr  = '0;
              state_next = ST_POP_ROOT;
            end
          end
        end
      end
      ST_UP_CHK: begin
        if (pos == '0) begin
          ram_we     = 1'b1;
          state_next = ST_OUT;
        end else begin
          ram_raddr  = parent;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          // parent moves down into the hole
          ram_wdata  = ram_rdata;
          pos_next   = parent;
          state_next = ST_UP_CHK;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_POP_ROOT: begin
        res_payload_next = rd_pay;
        count_next       = count - 1'b1;
        if (count == CW'(1)) begin
          state_next = ST_OUT;
        end else begin
          ram_raddr  = AW'(count - 1'b1);
          state_next = ST_POP_LAST;
        end
      end
      ST_POP_LAST: begin
        cur_pay_next = rd_pay;
        cur_key_next = rd_key;
        pos_next     = '0;
        state_next   = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (!l_ok) begin
          ram_we     = 1'b1;
          state_next = ST_OUT;
        end else begin
          ram_raddr  = l_ext[AW-1:0];
          state_next = ST_DN_L;
        end
      end
      ST_DN_L: begin
        if (cmp_lt) begin
          best_key_next   = rd_key;
          best_pay_next   = rd_pay;
          best_child_next = 1'b1;
          best_pos_next   = l_ext[AW-1:0];
        end else begin
          best_key_next   = cur_key;
          best_pay_next   = cur_pay;
          best_child_next = 1'b0;
        end
        if (r_ok) begin
          ram_raddr  = r_ext[AW-1:0];
          state_next = ST_DN_R;
        end else begin
          state_next = ST_DN_MOVE;
        end
      end
      ST_DN_R: begin
        // right wins only when strictly smaller, so ties stay left
        if (cmp_lt) begin
          best_key_next   = rd_key;
          best_pay_next   = rd_pay;
          best_child_next = 1'b1;
          best_pos_next   = r_ext[AW-1:0];
        end
        state_next = ST_DN_MOVE;
      end
      ST_DN_MOVE: begin
        ram_we = 1'b1;
        if (best_child) begin
          ram_wdata  = {best_pay, best_key};
          pos_next   = best_pos;
          state_next = ST_DN_CHK;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign payload_out  = PORT_WIDTH'(res_payload);
  assign status       = res_status;
  assign entries_left = count;
  assign is_empty     = (count == '0);

endmodule

// File: hdl/bmhq_checker.sv
// bmhq_checker: port-level checks for the binary min-heap queue
// uses bmhq_pkg; bound to binary_min_heap_queue below
`timescale 1ns / 1ps

module bmhq_checker #(
  parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [bmhq_pkg::PORT_WIDTH-1:0]       payload_out,
  input logic [1:0]                            status,
  input logic [$clog2(HEAP_DEPTH+1)-1:0]       entries_left,
  input logic                                  is_empty
);

  import bmhq_pkg::*;

  localparam int CW = $clog2(HEAP_DEPTH + 1);

  // one request at a time: never ready while a result is shown
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_out) && $stable(status)
      && $stable(entries_left))
    else $error("stalled result changed");

  // empty pop reports an empty heap and no payload
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> is_empty && payload_out == '0)
    else $error("empty pop with nonempty heap or payload");

  // a dropped push only happens at capacity
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> entries_left == CW'(HEAP_DEPTH) && payload_out == '0)
    else $error("full status below capacity");

  // count never passes capacity, and is_empty agrees with it
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entries_left <= CW'(HEAP_DEPTH) && is_empty == (entries_left == '0))
    else $error("entry count out of range");

endmodule

bind binary_min_heap_queue bmhq_checker #(
  .HEAP_DEPTH (HEAP_DEPTH)
) u_bmhq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_out  (payload_out),
  .status       (status),
  .entries_left (entries_left),
  .is_empty     (is_empty)
);

// File: sim/binary_min_heap_queue_tb.sv
`timescale 1ns / 1ps
// binary_min_heap_queue_tb: self-checking bench for the min-heap priority queue
// keeps a heap copy of its own to predict every result; needs bmhq_pkg and the queue rtl

module binary_min_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int DEPTH         = HEAP_DEPTH_DEF;
  localparam int COUNT_W       = $clog2(DEPTH + 1);
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [PORT_WIDTH-1:0] payload;
    status_t               status;
    logic [COUNT_W-1:0]    entries_left;
    logic                  is_empty;
  } heap_result_t;

  logic                        clk        = 1'b0;
  logic                        rst        = 1'b1;
  logic                        in_valid   = 1'b0;
  logic                        in_ready;
  logic                        func       = FUNC_PUSH;
  logic [PORT_WIDTH-1:0]       payload_in = '0;
  logic signed [KEY_WIDTH-1:0] key_in     = '0;
  logic                        out_valid;
  logic                        out_ready  = 1'b0;
  logic [PORT_WIDTH-1:0]       payload_out;
  logic [1:0]                  status;
  logic [COUNT_W-1:0]          entries_left;
  logic                        is_empty;

  // predicted heap contents, updated as each request is taken
  logic [PORT_WIDTH-1:0]       heap_payload [DEPTH];
  logic signed [KEY_WIDTH-1:0] heap_key     [DEPTH];
  int                          heap_count = 0;

  heap_result_t pending_results [$];
  int           error_count = 0;
  bit           no_idle     = 1'b0;

  binary_min_heap_queue uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .payload_in   (payload_in),
    .key_in       (key_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_out  (payload_out),
    .status       (status),
    .entries_left (entries_left),
    .is_empty     (is_empty)
  );

  always #1 clk = ~clk;

  function automatic void swap_heap_entries(int a, int b);
    logic [PORT_WIDTH-1:0]       p;
    logic signed [KEY_WIDTH-1:0] k;
    p = heap_payload[a];
    k = heap_key[a];
    heap_payload[a] = heap_payload[b];
    heap_key[a]     = heap_key[b];
    heap_payload[b] = p;
    heap_key[b]     = k;
  endfunction

  function automatic heap_result_t apply_request(func_t op, logic [PORT_WIDTH-1:0] pl,
                                                 logic signed [KEY_WIDTH-1:0] k);
    heap_result_t r;
    int           pos;
    int           parent;
    int           left;
    int           right;
    int           best;
    r = '0;
    r.status = STAT_OK;
    if (op == FUNC_PUSH) begin
      if (heap_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = heap_count;
        heap_payload[pos] = pl;
        heap_key[pos]     = k;
        heap_count++;
        while (pos != 0) begin
          parent = (pos - 1) / 2;
          if (heap_key[parent] <= heap_key[pos]) break;
          swap_heap_entries(pos, parent);
          pos = parent;
        end
      end
    end else if (heap_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.payload = heap_payload[0];
      heap_count--;
      if (heap_count != 0) begin
        heap_payload[0] = heap_payload[heap_count];
        heap_key[0]     = heap_key[heap_count];
        pos = 0;
        forever begin
          left  = 2 * pos + 1;
          right = left + 1;
          best  = pos;
          // strict compares: left wins a tie, and an equal child leaves the entry put
          if (left < heap_count && heap_key[left] < heap_key[best]) best = left;
          if (right < heap_count && heap_key[right] < heap_key[best]) best = right;
          if (best == pos) break;
          swap_heap_entries(pos, best);
          pos = best;
        end
      end
    end
    r.entries_left = COUNT_W'(heap_count);
    r.is_empty     = (heap_count == 0);
    return r;
  endfunction

  function automatic logic signed [KEY_WIDTH-1:0] random_key();
    case ($urandom_range(0, 3))
      // narrow band around zero so ties are common
      0: return KEY_WIDTH'($urandom_range(0, 8)) - KEY_WIDTH'(4);
      1: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input func_t op, input logic [PORT_WIDTH-1:0] pl,
                              input logic signed [KEY_WIDTH-1:0] k);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= op;
    payload_in <= pl;
    key_in     <= k;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(op, pl, k));
  endtask

  task automatic send_random_request(input int push_pct);
    func_t op;
    op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
    send_request(op, $urandom, random_key());
  endtask

  // hold off new requests until every outstanding result is back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic log_mismatch(input string what, input heap_result_t want,
                              input heap_result_t got);
    if (error_count < MAX_REPORTS) begin
      $display("%0t: %s: exp payload %h status %0d entries %0d empty %0d",
               $realtime, what, want.payload, want.status, want.entries_left,
               want.is_empty);
      $display("%0t: %s: got payload %h status %0d entries %0d empty %0d",
               $realtime, what, got.payload, got.status, got.entries_left,
               got.is_empty);
    end
    error_count++;
  endtask

  task automatic test_pop_empty();
    repeat (2) send_request(FUNC_POP, $urandom, $urandom);
  endtask

  task automatic test_extreme_keys();
    send_request(FUNC_PUSH, 32'h0000_0000, 32'h7fff_ffff);
    send_request(FUNC_PUSH, 32'hffff_ffff, 32'h8000_0000);
    send_request(FUNC_PUSH, 32'ha5a5_a5a5, 32'h0000_0000);
    send_request(FUNC_PUSH, 32'h5a5a_5a5a, 32'hffff_ffff);
    send_request(FUNC_PUSH, 32'h0000_0001, 32'h0000_0001);
    send_request(FUNC_PUSH, 32'h8000_0000, 32'h0001_0000);
    repeat (7) send_request(FUNC_POP, $urandom, $urandom);
  endtask

  task automatic test_equal_keys();
    for (int i = 1; i <= 5; i++) send_request(FUNC_PUSH, i, 32'h0002_8000);
    repeat (5) send_request(FUNC_POP, $urandom, $urandom);
  endtask

  task automatic test_full_heap();
    while (heap_count < DEPTH) send_request(FUNC_PUSH, $urandom, random_key());
    repeat (2) send_request(FUNC_PUSH, $urandom, random_key());
    while (heap_count > 0) send_request(FUNC_POP, $urandom, $urandom);
    send_request(FUNC_POP, $urandom, $urandom);
  endtask

  // phases lean toward push or pop, or mix them evenly, so the heap swings between empty and full
  task automatic test_random_mix(input int n);
    int sent;
    int phase_len;
    int push_pct;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 2))
        0: push_pct = 25;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      phase_len = $urandom_range(20, 120);
      for (int i = 0; i < phase_len && sent < n; i++) begin
        send_random_request(push_pct);
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back(input int n);
    no_idle = 1'b1;
    for (int i = 0; i < n; i++) send_random_request((i % 160 < 90) ? 75 : 30);
    no_idle = 1'b0;
  endtask

  initial begin : result_checker
    heap_result_t got;
    heap_result_t want;
    int           stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.payload      = payload_out;
      got.status       = status_t'(status);
      got.entries_left = entries_left;
      got.is_empty     = is_empty;
      if (pending_results.size() == 0) begin
        log_mismatch("result with no request pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) log_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_pop_empty();
    test_extreme_keys();
    test_equal_keys();
    wait_results_drained();
    test_full_heap();
    wait_results_drained();
    test_random_mix(1350);
    test_back_to_back(250);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
